>>> hw/rtl/xsort_pkg.sv
// ----------------------------------------------------------------------------
// Exchange sorter package
// Shared widths, default sizing and the sequencer state type.
// ----------------------------------------------------------------------------
package xsort_pkg;

   // Width of one element and of the sorted result.
   localparam int DATA_WIDTH = 16;

   // Default capacity of the element store.
   localparam int MAX_ELEMENTS_DEFAULT = 32;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ROW,
      ST_FIRST,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/xsort_if.sv
// ----------------------------------------------------------------------------
// Exchange sorter channels
// Valid/ready interfaces for the element input and the sorted result output.
// ----------------------------------------------------------------------------

// Input channel: one element of the set per item.
interface xsort_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [xsort_pkg::DATA_WIDTH-1:0]     value;
   logic                                        final_item;

   modport source (output valid, input ready, output value, output final_item);
   modport sink   (input valid, output ready, input value, input final_item);
endinterface

// Result channel: one sorted element per item.
interface xsort_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [xsort_pkg::DATA_WIDTH-1:0]     sorted_value;
   logic                                        final_result;

   modport source (output valid, input ready, output sorted_value, output final_result);
   modport sink   (input valid, output ready, input sorted_value, input final_result);
endinterface

>>> hw/rtl/ascending_exchange_sorter.sv
// ----------------------------------------------------------------------------
// Ascending exchange sorter
// Collects a set of signed elements, sorts it by exchange sort and emits
// the elements smallest first, flagging the largest as the final one.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload                       Role
//   req_chan  in          value, final_item             one element per item
//   rsp_chan  out         sorted_value, final_result    one sorted element per item
//
// Loading takes one item per cycle. After the closing item, each row of the
// sort reads its row element and then every later element through the single
// RAM read port, then emits the settled row minimum as one result item.
// Input is not ready from the closing item until the last result of the set
// has been taken.
// Reset is synchronous and clears the sequencer and the element count; the
// store needs no clearing. A stalled result holds the sequencer in place.
// ----------------------------------------------------------------------------
module ascending_exchange_sorter #(
   parameter int MAX_ELEMENTS = xsort_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   xsort_req_if.sink   req_chan,
   xsort_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);
   localparam int DW = xsort_pkg::DATA_WIDTH;

   xsort_pkg::state_type state_ff, state_in;

   logic [CW-1:0]        count_ff, count_in;   // elements loaded so far
   logic [CW-1:0]        size_ff, size_in;     // size of the set being sorted
   logic [AW-1:0]        row_ff, row_in;       // position being settled
   logic [CW-1:0]        col_ff, col_in;       // next position to read in a row
   logic signed [DW-1:0] cur_ff, cur_in;       // running minimum of the row

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [DW-1:0]        ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [DW-1:0]        ram_rd_data;

   logic [CW-1:0]        loaded_next;
   logic [CW-1:0]        scan_addr;
   logic                 last_row;

   // Element store.
   xsort_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_ELEMENTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xsort_pkg::ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      size_ff <= size_in;
      row_ff  <= row_in;
      col_ff  <= col_in;
      cur_ff  <= cur_in;
   end

   assign scan_addr = col_ff - CW'(1);
   assign last_row  = (CW'(row_ff) == size_ff - CW'(1));

   // Result item comes straight from the settled row minimum.
   assign rsp_chan.sorted_value = cur_ff;
   assign rsp_chan.final_result = last_row;

   // Next state, store access and handshakes.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      size_in     = size_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      cur_in      = cur_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[AW-1:0];
      ram_wr_data = req_chan.value;
      ram_rd_addr = row_ff;
      loaded_next = count_ff;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;

      case (state_ff)
         xsort_pkg::ST_LOAD: begin
            // Store each element while there is room; a full store drops it.
            req_chan.ready = 1'b1;
            if (count_ff < CW'(MAX_ELEMENTS)) begin
               loaded_next = count_ff + CW'(1);
            end
            if (req_chan.valid) begin
               ram_wr_en = (count_ff < CW'(MAX_ELEMENTS));
               if (req_chan.final_item) begin
                  size_in  = loaded_next;
                  count_in = '0;
                  row_in   = '0;
                  state_in = xsort_pkg::ST_ROW;
               end else begin
                  count_in = loaded_next;
               end
            end
         end

         xsort_pkg::ST_ROW: begin
            // Fetch the element at the row position.
            ram_rd_addr = row_ff;
            col_in      = CW'(row_ff) + CW'(1);
            state_in    = xsort_pkg::ST_FIRST;
         end

         xsort_pkg::ST_FIRST: begin
            // The row element becomes the running minimum; start the scan.
            cur_in = $signed(ram_rd_data);
            if (col_ff < size_ff) begin
               ram_rd_addr = col_ff[AW-1:0];
               col_in      = col_ff + CW'(1);
               state_in    = xsort_pkg::ST_SCAN;
            end else begin
               state_in = xsort_pkg::ST_EMIT;
            end
         end

         xsort_pkg::ST_SCAN: begin
            // A smaller later element swaps with the row element.
            if ($signed(ram_rd_data) < cur_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = scan_addr[AW-1:0];
               ram_wr_data = cur_ff;
               cur_in      = $signed(ram_rd_data);
            end
            if (col_ff < size_ff) begin
               ram_rd_addr = col_ff[AW-1:0];
               col_in      = col_ff + CW'(1);
            end else begin
               state_in = xsort_pkg::ST_EMIT;
            end
         end

         xsort_pkg::ST_EMIT: begin
            // The row is settled; hand its element out.
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               if (last_row) begin
                  state_in = xsort_pkg::ST_LOAD;
               end else begin
                  row_in   = row_ff + AW'(1);
                  state_in = xsort_pkg::ST_ROW;
               end
            end
         end

         default: begin
            state_in = xsort_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

>>> hw/rtl/xsort_ram.sv
// ----------------------------------------------------------------------------
// Exchange sorter RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module xsort_ram #(
   parameter int WIDTH = xsort_pkg::DATA_WIDTH,
   parameter int DEPTH = xsort_pkg::MAX_ELEMENTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/tb_ascending_exchange_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ascending exchange sorter testbench
// Feeds sets of signed elements through the input channel under random
// bursts and gaps, while the result channel stalls on its own pattern.
// A local sorter predicts every result in order, and each result is checked
// field by field. The stimulus covers sets of one, equal values, extreme
// values and sets that overflow the element store.
// ----------------------------------------------------------------------------
module tb_ascending_exchange_sorter;

   localparam int CAPACITY    = xsort_pkg::MAX_ELEMENTS_DEFAULT;
   localparam int DW          = xsort_pkg::DATA_WIDTH;
   localparam int ITEM_TARGET = 320;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 50;

   // One element item as offered on the input channel.
   typedef struct {
      logic signed [DW-1:0] value;
      logic                 closing;
   } element_item_type;

   // One sorted result as expected on the output channel.
   typedef struct {
      logic signed [DW-1:0] value;
      logic                 largest;
   } sorted_elem_type;

   // Receiver behavior for one stretch of cycles.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_PATTERN,
      RX_SPARSE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xsort_req_if req_bus ();
   xsort_rsp_if rsp_bus ();

   ascending_exchange_sorter #(
      .MAX_ELEMENTS (CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   element_item_type pending_items[$];
   sorted_elem_type  sorted_due[$];

   // Predictor state: the elements of the set being collected.
   logic signed [DW-1:0] set_store[CAPACITY];
   int unsigned          held_count = 0;

   int   error_count    = 0;
   int   results_seen   = 0;
   int   sets_closed    = 0;
   int   items_taken    = 0;
   int   items_dropped  = 0;
   int   overflow_sets  = 0;
   int   largest_set    = 0;
   int   cycle_count    = 0;
   logic req_took       = 1'b0;
   logic set_overflowed = 1'b0;

   // Sender pacing.
   int burst_left = 0;
   int gap_left   = 0;

   // Receiver pacing.
   rx_mode_type rx_mode    = RX_OPEN;
   int          rx_stretch = 0;
   logic [31:0] rx_pattern = '1;

   // Appends one element item to the sender's queue.
   task automatic queue_element(input logic signed [DW-1:0] value,
                                input logic closing);
      element_item_type item;
      item.value   = value;
      item.closing = closing;
      pending_items.push_back(item);
   endtask

   // Takes one accepted element. A closing item sorts the held set by
   // exchange sort and queues the sorted results, smallest first.
   task automatic absorb_element(input element_item_type item);
      logic signed [DW-1:0] work[CAPACITY];
      logic signed [DW-1:0] hold;
      sorted_elem_type      res;

      items_taken++;
      if (held_count < CAPACITY) begin
         set_store[held_count] = item.value;
         held_count++;
      end else begin
         items_dropped++;
         set_overflowed = 1'b1;
      end
      if (item.closing) begin
         work = set_store;
         for (int i = 0; i < held_count; i++) begin
            for (int j = i + 1; j < held_count; j++) begin
               if (work[j] < work[i]) begin
                  hold    = work[i];
                  work[i] = work[j];
                  work[j] = hold;
               end
            end
         end
         for (int k = 0; k < held_count; k++) begin
            res.value   = work[k];
            res.largest = (k == held_count - 1);
            sorted_due.push_back(res);
         end
         sets_closed++;
         if (set_overflowed) begin
            overflow_sets++;
         end
         if (held_count > largest_set) begin
            largest_set = held_count;
         end
         held_count     = 0;
         set_overflowed = 1'b0;
      end
   endtask

   // Monitor: checks results and feeds accepted items to the predictor.
   always @(posedge clock) begin
      element_item_type seen;
      sorted_elem_type  want;

      cycle_count <= cycle_count + 1;
      req_took    <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         // A result is compared before this edge's input item is absorbed.
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (sorted_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result: expected none, actual value %0d final %0b",
                        $time, rsp_bus.sorted_value, rsp_bus.final_result);
            end else begin
               want = sorted_due.pop_front();
               if (rsp_bus.sorted_value !== want.value) begin
                  error_count++;
                  $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                           $time, want.value, rsp_bus.sorted_value);
               end
               if (rsp_bus.final_result !== want.largest) begin
                  error_count++;
                  $display("%0t: final_result mismatch: expected %0b, actual %0b",
                           $time, want.largest, rsp_bus.final_result);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.value   = req_bus.value;
            seen.closing = req_bus.final_item;
            absorb_element(seen);
         end
      end
   end

   // Driver: presents queued items in bursts separated by random gaps.
   always @(negedge clock) begin
      element_item_type nxt;
      logic             drive;

      drive = 1'b0;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.value      <= '0;
         req_bus.final_item <= 1'b0;
      end else if (!req_bus.valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_items.size() > 0) begin
            nxt   = pending_items.pop_front();
            drive = 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end
            if (burst_left == 0) begin
               // New burst: sometimes a long unbroken stretch, otherwise short.
               if ($urandom_range(0, 3) == 0) begin
                  burst_left = $urandom_range(16, 48);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 8);
                  gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                           : $urandom_range(1, 6);
               end
            end
         end
         req_bus.valid <= drive;
         if (drive) begin
            req_bus.value      <= nxt.value;
            req_bus.final_item <= nxt.closing;
         end else begin
            req_bus.value      <= DW'($urandom);
            req_bus.final_item <= 1'($urandom_range(0, 1));
         end
      end
   end

   // Receiver: ready follows a mode that changes every stretch of cycles.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rx_stretch == 0) begin
            rx_stretch = $urandom_range(20, 80);
            rx_pattern = $urandom;
            case ($urandom_range(0, 2))
               0: rx_mode = RX_OPEN;
               1: rx_mode = RX_PATTERN;
               default: rx_mode = RX_SPARSE;
            endcase
         end
         rx_stretch--;
         case (rx_mode)
            RX_OPEN: begin
               rsp_bus.ready <= 1'b1;
            end
            RX_PATTERN: begin
               rsp_bus.ready <= rx_pattern[0];
               rx_pattern     = {rx_pattern[0], rx_pattern[31:1]};
            end
            default: begin
               rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still expected",
                  $time, cycle_count, sorted_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int          set_len;
      int          pick;
      int          planned;
      logic        few_values;
      logic [15:0] pool[4];
      logic [15:0] val;

      // Sets of one at both extremes.
      queue_element(16'h8000, 1'b1);
      queue_element(16'h7FFF, 1'b1);
      // Extremes, alternating bit patterns and repeated values in one set.
      queue_element(16'h7FFF, 1'b0);
      queue_element(16'h8000, 1'b0);
      queue_element(16'h0000, 1'b0);
      queue_element(16'hFFFF, 1'b0);
      queue_element(16'h0001, 1'b0);
      queue_element(16'h5555, 1'b0);
      queue_element(16'hAAAA, 1'b0);
      queue_element(16'h0000, 1'b0);
      queue_element(16'h7FFF, 1'b0);
      queue_element(16'h8000, 1'b1);
      // A strictly descending set, worst case for swapping.
      for (int k = 0; k < 5; k++) begin
         queue_element(16'(500 - 250 * k), (k == 4));
      end
      // All elements equal: nothing may move.
      for (int k = 0; k < 3; k++) begin
         queue_element(16'd7, (k == 2));
      end

      // Random sets, mostly small; the first one overflows the store.
      planned = 0;
      while (planned < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (planned == 0 || pick < 8) begin
            set_len = $urandom_range(CAPACITY + 1, CAPACITY + 8);
         end else if (pick < 25) begin
            set_len = $urandom_range(9, CAPACITY);
         end else begin
            set_len = $urandom_range(1, 8);
         end
         few_values = ($urandom_range(0, 3) == 0);
         for (int p = 0; p < 4; p++) begin
            pool[p] = 16'($urandom);
         end
         for (int k = 0; k < set_len; k++) begin
            if (few_values) begin
               val = pool[$urandom_range(0, 3)];
            end else if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0: val = 16'h8000;
                  1: val = 16'h7FFF;
                  2: val = 16'h0000;
                  default: val = 16'hFFFF;
               endcase
            end else begin
               val = 16'($urandom);
            end
            queue_element(val, (k == set_len - 1));
         end
         planned += set_len;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_items.size() > 0 || req_bus.valid) begin
         @(posedge clock);
      end
      while (sorted_due.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Run covered %0d sets from %0d items, largest set %0d elements.",
               sets_closed, items_taken, largest_set);
      $display("%0d results checked; %0d items dropped past capacity in %0d sets.",
               results_seen, items_dropped, overflow_sets);
      if (error_count == 0 && sorted_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/xsort_pkg.sv
hw/rtl/xsort_if.sv
hw/rtl/xsort_ram.sv
hw/rtl/ascending_exchange_sorter.sv
tb/tb_ascending_exchange_sorter.sv
